FILE: hw/rtl/rfoc_pkg.sv
package rfoc_pkg;

    localparam int RFOC_MAX_WIDTH  = 256;
    localparam int RFOC_MAX_HEIGHT = 256;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] ACTIVE_WIDTH_RST  = 9'd256;
    localparam logic [CFG_W-1:0] ACTIVE_HEIGHT_RST = 9'd256;

    typedef enum logic [1:0] {
        KIND_FILL    = 2'd0,
        KIND_OUTLINE = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_READ    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PREP,
        ST_FILL,
        ST_COL,
        ST_ROW,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

FILE: hw/rtl/rect_fill_outline_clip.sv
// Rectangle blitter over a single-port frame store of MAX_WIDTH * MAX_HEIGHT 32-bit words,
// addressed x + y * active_width. Commands are taken on start while busy is low; each one
// gives exactly one result beat on o_valid, which must be taken in that cycle. The frame
// store port does one access per cycle: a fill or clear writes each clipped pixel once, an
// outline writes both side columns of each clipped row and the bottom and top rows of each
// clipped column, a pixel read reads one word, and a command that draws nothing skips the
// frame store. Words never written read back as unknown.
module rect_fill_outline_clip
    import rfoc_pkg::*;
#(
    parameter int MAX_WIDTH  = RFOC_MAX_WIDTH,
    parameter int MAX_HEIGHT = RFOC_MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_start,
    input  logic [1:0]                 i_kind,
    input  logic signed [COORD_W-1:0]  i_left,
    input  logic signed [COORD_W-1:0]  i_bottom,
    input  logic signed [COORD_W-1:0]  i_width,
    input  logic signed [COORD_W-1:0]  i_height,
    input  logic [COLOR_W-1:0]         i_color,
    output logic                       o_busy,
    output logic                       o_valid,
    output logic [COLOR_W-1:0]         o_pixel_value,
    output logic                       o_visible
);

    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state r_state, n_state;

    logic [CFG_W-1:0]          r_active_width;
    logic [CFG_W-1:0]          r_active_height;

    t_kind                     r_kind;
    logic signed [COORD_W-1:0] r_left, r_bottom, r_wd, r_ht;
    logic [COLOR_W-1:0]        r_color;

    logic [XW-1:0]             r_l, r_r, r_xlast, r_x;
    logic [YW-1:0]             r_b, r_t, r_ylast, r_y;
    logic [AW-1:0]             r_row, r_row_b;
    logic                      r_side;
    logic                      r_vis;
    logic [COLOR_W-1:0]        r_rdata;

    logic [COLOR_W-1:0]        mem [DEPTH];

    logic [XW-1:0]             s_w;
    logic [YW-1:0]             s_h;
    logic signed [COORD_W:0]   s_left, s_bottom, s_right, s_top, s_wx, s_hx;
    logic                      s_hit;
    logic [XW-1:0]             s_l, s_r;
    logic [YW-1:0]             s_b, s_t;
    logic [XW+YW-1:0]          s_prod;
    logic                      s_x_end, s_y_end;

    logic                      mem_we, mem_re;
    logic [AW-1:0]             mem_addr;

    // effective active size
    always_comb begin
        if (r_active_width == '0) begin
            s_w = XW'(1);
        end else if (32'(r_active_width) > MAX_WIDTH) begin
            s_w = XW'(MAX_WIDTH);
        end else begin
            s_w = XW'(r_active_width);
        end
        if (r_active_height == '0) begin
            s_h = YW'(1);
        end else if (32'(r_active_height) > MAX_HEIGHT) begin
            s_h = YW'(MAX_HEIGHT);
        end else begin
            s_h = YW'(r_active_height);
        end
    end

    // culling and clamping
    always_comb begin
        s_left   = {r_left[COORD_W-1], r_left};
        s_bottom = {r_bottom[COORD_W-1], r_bottom};
        s_right  = s_left + {r_wd[COORD_W-1], r_wd};
        s_top    = s_bottom + {r_ht[COORD_W-1], r_ht};
        s_wx     = $signed((COORD_W+1)'(s_w));
        s_hx     = $signed((COORD_W+1)'(s_h));
        s_hit    = 1'b0;
        s_l      = '0;
        s_r      = s_w;
        s_b      = '0;
        s_t      = s_h;
        case (r_kind)
            KIND_CLEAR: begin
                s_hit = 1'b1;
            end
            KIND_READ: begin
                s_hit = (s_left >= 0) && (s_left < s_wx) && (s_bottom >= 0) && (s_bottom < s_hx);
                s_l   = XW'(r_left);
                s_b   = YW'(r_bottom);
            end
            default: begin
                s_hit = (r_wd > 0) && (r_ht > 0) && (s_right > 0) && (s_left < s_wx)
                        && (s_top > 0) && (s_bottom < s_hx);
                s_l   = (s_left < 0) ? '0 : XW'(r_left);
                s_r   = (s_right > s_wx) ? s_w : XW'(s_right);
                s_b   = (s_bottom < 0) ? '0 : YW'(r_bottom);
                s_t   = (s_top > s_hx) ? s_h : YW'(s_top);
            end
        endcase
    end

    assign s_prod  = (XW+YW)'(r_b) * (XW+YW)'(s_w);
    assign s_x_end = (r_x == r_xlast);
    assign s_y_end = (r_y == r_ylast);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = s_hit ? ST_PREP : ST_DONE;
            end
            ST_PREP: begin
                case (r_kind)
                    KIND_OUTLINE: n_state = ST_COL;
                    KIND_READ:    n_state = ST_READ;
                    default:      n_state = ST_FILL;
                endcase
            end
            ST_FILL: begin
                if (s_x_end && s_y_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_COL: begin
                if (r_side && s_y_end) begin
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                if (r_side && s_x_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs and frame store access
    always_comb begin
        o_busy        = (r_state != ST_IDLE);
        o_valid       = 1'b0;
        o_pixel_value = '0;
        o_visible     = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = r_row + AW'(r_x);
        case (r_state)
            ST_FILL: begin
                mem_we = 1'b1;
            end
            ST_COL: begin
                mem_we   = 1'b1;
                mem_addr = r_row + AW'(r_side ? r_xlast : r_l);
            end
            ST_ROW: begin
                mem_we   = 1'b1;
                mem_addr = (r_side ? r_row : r_row_b) + AW'(r_x);
            end
            ST_READ: begin
                mem_re = 1'b1;
            end
            ST_DONE: begin
                o_valid       = 1'b1;
                o_visible     = r_vis;
                o_pixel_value = (r_vis && r_kind == KIND_READ) ? r_rdata : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_active_width  <= ACTIVE_WIDTH_RST;
            r_active_height <= ACTIVE_HEIGHT_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTIVE_WIDTH:  r_active_width  <= i_cfg_data;
                    CFG_ACTIVE_HEIGHT: r_active_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // command and walk registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_kind   <= t_kind'(i_kind);
                r_left   <= i_left;
                r_bottom <= i_bottom;
                r_wd     <= i_width;
                r_ht     <= i_height;
                r_color  <= i_color;
            end
            ST_SETUP: begin
                r_vis <= s_hit;
                r_l   <= s_l;
                r_r   <= s_r;
                r_b   <= s_b;
                r_t   <= s_t;
            end
            ST_PREP: begin
                r_row   <= AW'(s_prod);
                r_row_b <= AW'(s_prod);
                r_x     <= r_l;
                r_y     <= r_b;
                r_xlast <= r_r - XW'(1);
                r_ylast <= r_t - YW'(1);
                r_side  <= 1'b0;
            end
            ST_FILL: begin
                if (s_x_end) begin
                    r_x <= r_l;
                    if (!s_y_end) begin
                        r_y   <= r_y + YW'(1);
                        r_row <= r_row + AW'(s_w);
                    end
                end else begin
                    r_x <= r_x + XW'(1);
                end
            end
            ST_COL: begin
                r_side <= !r_side;
                if (r_side && !s_y_end) begin
                    r_y   <= r_y + YW'(1);
                    r_row <= r_row + AW'(s_w);
                end
            end
            ST_ROW: begin
                r_side <= !r_side;
                if (r_side && !s_x_end) begin
                    r_x <= r_x + XW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_busy)
        else $error("busy held after result beat");

    a_start_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_valid))
        else $error("accepted command did not start");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we || mem_re) |-> ({1'b0, mem_addr} < (AW+1)'(DEPTH)))
        else $error("frame store address out of range");

    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> ((r_x <= r_xlast) && (r_y <= r_ylast)))
        else $error("fill walk left the clipped rectangle");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_pixel_value == '0))
        else $error("pixel value on a hidden result");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rfoc_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] left;
        logic [15:0] bottom;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] color;
    } blit_cmd_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic        vis;
    } blit_res_t;

    typedef struct packed {
        logic      typed;
        blit_cmd_t cmd;
        blit_res_t res;
    } blit_row_t;

    localparam int FRAME_WORDS = RFOC_MAX_WIDTH * RFOC_MAX_HEIGHT;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 58;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      i_start;
    logic [1:0]                i_kind;
    logic signed [COORD_W-1:0] i_left;
    logic signed [COORD_W-1:0] i_bottom;
    logic signed [COORD_W-1:0] i_width;
    logic signed [COORD_W-1:0] i_height;
    logic [COLOR_W-1:0]        i_color;
    logic                      o_busy;
    logic                      o_valid;
    logic [COLOR_W-1:0]        o_pixel_value;
    logic                      o_visible;

    rect_fill_outline_clip u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start       (i_start),
        .i_kind        (i_kind),
        .i_left        (i_left),
        .i_bottom      (i_bottom),
        .i_width       (i_width),
        .i_height      (i_height),
        .i_color       (i_color),
        .o_busy        (o_busy),
        .o_valid       (o_valid),
        .o_pixel_value (o_pixel_value),
        .o_visible     (o_visible)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [31:0] shadow_frame [0:FRAME_WORDS-1];
    logic [8:0]  width_setting;
    logic [8:0]  height_setting;
    blit_res_t   results_due [$];
    blit_res_t   due_res;
    int          mismatches;
    int          results_seen;
    int          settings_used;
    int          kind_seen [4];
    blit_row_t   plan [0:26];
    logic [8:0]  phase_w [0:PHASES-1] = '{9'd1, 9'd0, 9'd17, 9'd511, 9'd2,
                                          9'd300, 9'd64, 9'd255, 9'd40, 9'd256};
    logic [8:0]  phase_h [0:PHASES-1] = '{9'd1, 9'd0, 9'd9, 9'd3, 9'd511,
                                          9'd300, 9'd48, 9'd255, 9'd100, 9'd256};

    function automatic int span(logic [8:0] v, int lim);
        return (v == 9'd0) ? 1 : ((int'(v) > lim) ? lim : int'(v));
    endfunction

    function automatic int clip(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    function automatic blit_row_t row(logic typed, t_kind k, int l, int b, int wd, int ht,
                                      logic [31:0] col, logic [31:0] px, logic v);
        blit_row_t e;
        e.typed = typed;
        e.cmd.kind = k;
        e.cmd.left = l[15:0];
        e.cmd.bottom = b[15:0];
        e.cmd.width = wd[15:0];
        e.cmd.height = ht[15:0];
        e.cmd.color = col;
        e.res.pixel = px;
        e.res.vis = v;
        return e;
    endfunction

    // blit model: updates the shadow frame and returns the result beat
    task automatic blit_predict(input blit_cmd_t c, output blit_res_t r);
        int w, h, lf, bt, wd, ht, l, rt, b, tp, x, y;
        w = span(width_setting, RFOC_MAX_WIDTH);
        h = span(height_setting, RFOC_MAX_HEIGHT);
        lf = int'($signed(c.left));
        bt = int'($signed(c.bottom));
        wd = int'($signed(c.width));
        ht = int'($signed(c.height));
        r.pixel = '0;
        r.vis = 1'b0;
        case (c.kind)
            KIND_CLEAR: begin
                for (y = 0; y < h; y++)
                    for (x = 0; x < w; x++)
                        shadow_frame[x + y * w] = c.color;
                r.vis = 1'b1;
            end
            KIND_READ: begin
                if (lf >= 0 && lf < w && bt >= 0 && bt < h) begin
                    r.pixel = shadow_frame[lf + bt * w];
                    r.vis = 1'b1;
                end
            end
            default: begin
                if (wd > 0 && ht > 0 && lf + wd > 0 && lf < w && bt + ht > 0 && bt < h) begin
                    l = clip(lf, w);
                    rt = clip(lf + wd, w);
                    b = clip(bt, h);
                    tp = clip(bt + ht, h);
                    if (c.kind == KIND_FILL) begin
                        for (y = b; y < tp; y++)
                            for (x = l; x < rt; x++)
                                shadow_frame[x + y * w] = c.color;
                    end else begin
                        for (y = b; y < tp; y++) begin
                            shadow_frame[l + y * w] = c.color;
                            shadow_frame[rt - 1 + y * w] = c.color;
                        end
                        for (x = l; x < rt; x++) begin
                            shadow_frame[x + b * w] = c.color;
                            shadow_frame[x + (tp - 1) * w] = c.color;
                        end
                    end
                    r.vis = 1'b1;
                end
            end
        endcase
    endtask

    task automatic issue(input blit_cmd_t c, input int gap, input logic typed,
                         input blit_res_t typed_res);
        blit_res_t r;
        @(negedge i_clk);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_kind <= c.kind;
        i_left <= c.left;
        i_bottom <= c.bottom;
        i_width <= c.width;
        i_height <= c.height;
        i_color <= c.color;
        do @(posedge i_clk); while (o_busy);
        blit_predict(c, r);
        results_due.push_back(typed ? typed_res : r);
        kind_seen[c.kind]++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (results_due.size() != 0 || o_busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_area(input logic [8:0] wv, input logic [8:0] hv);
        logic width_first;
        width_first = 1'($urandom_range(1));
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= width_first ? CFG_ACTIVE_WIDTH : CFG_ACTIVE_HEIGHT;
        i_cfg_data <= width_first ? wv : hv;
        @(negedge i_clk);
        i_cfg_index <= width_first ? CFG_ACTIVE_HEIGHT : CFG_ACTIVE_WIDTH;
        i_cfg_data <= width_first ? hv : wv;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        width_setting = wv;
        height_setting = hv;
        settings_used++;
    endtask

    task automatic roll_cmd(output blit_cmd_t c);
        int w, h, pick, lf, bt, wd, ht;
        logic heavy;
        w = span(width_setting, RFOC_MAX_WIDTH);
        h = span(height_setting, RFOC_MAX_HEIGHT);
        heavy = (w * h > 4096);
        pick = int'($urandom_range(99));
        c.kind = KIND_READ;
        c.left = 16'($urandom);
        c.bottom = 16'($urandom);
        c.width = 16'($urandom);
        c.height = 16'($urandom);
        c.color = $urandom;
        if (pick < 15) begin
            // raw noise; on big areas fills and clears become outlines to bound the cycle count
            c.kind = t_kind'($urandom_range(3));
            if (heavy && (c.kind == KIND_FILL || c.kind == KIND_CLEAR))
                c.kind = KIND_OUTLINE;
        end else if (pick < 50) begin
            if ($urandom_range(3) != 0) begin
                lf = int'($urandom_range(w - 1));
                bt = int'($urandom_range(h - 1));
            end else begin
                lf = $urandom_range(1) ? w + int'($urandom_range(40))
                                       : -1 - int'($urandom_range(40));
                bt = int'($urandom_range(h + 5)) - 2;
                if ($urandom_range(1)) begin
                    wd = lf;
                    lf = bt;
                    bt = wd;
                end
            end
            c.left = lf[15:0];
            c.bottom = bt[15:0];
        end else if (pick < 55 && !heavy) begin
            c.kind = KIND_CLEAR;
        end else begin
            c.kind = $urandom_range(1) ? KIND_FILL : KIND_OUTLINE;
            lf = int'($urandom_range(w + 20)) - 10;
            bt = int'($urandom_range(h + 20)) - 10;
            wd = int'($urandom_range(26)) - 2;
            ht = int'($urandom_range(26)) - 2;
            if (!heavy && $urandom_range(2) == 0) begin
                wd = int'($urandom_range(32767));
                ht = int'($urandom_range(32767));
                lf = -int'($urandom_range(300));
                bt = -int'($urandom_range(300));
            end else if (heavy && $urandom_range(9) == 0) begin
                if ($urandom_range(1)) begin
                    wd = 32767;
                    ht = int'($urandom_range(1, 8));
                    lf = -int'($urandom_range(32768));
                end else begin
                    ht = 32767;
                    wd = int'($urandom_range(1, 8));
                    bt = -int'($urandom_range(32768));
                end
            end
            c.left = lf[15:0];
            c.bottom = bt[15:0];
            c.width = wd[15:0];
            c.height = ht[15:0];
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (results_due.size() == 0) begin
                $display("%0t: result beat with nothing expected: pixel %h visible %b",
                         $time, o_pixel_value, o_visible);
                mismatches++;
            end else begin
                due_res = results_due.pop_front();
                if (o_pixel_value !== due_res.pixel) begin
                    $display("%0t: pixel_value expected %h actual %h",
                             $time, due_res.pixel, o_pixel_value);
                    mismatches++;
                end
                if (o_visible !== due_res.vis) begin
                    $display("%0t: visible expected %b actual %b",
                             $time, due_res.vis, o_visible);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #150_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        blit_cmd_t cmd;
        int p, n, gap_max;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_ACTIVE_WIDTH;
        i_cfg_data = '0;
        i_start = 1'b0;
        i_kind = KIND_FILL;
        i_left = '0;
        i_bottom = '0;
        i_width = '0;
        i_height = '0;
        i_color = '0;
        width_setting = ACTIVE_WIDTH_RST;
        height_setting = ACTIVE_HEIGHT_RST;
        mismatches = 0;
        results_seen = 0;
        settings_used = 1;
        foreach (kind_seen[k]) kind_seen[k] = 0;
        foreach (shadow_frame[a]) shadow_frame[a] = '0;
        // the full clear in the second row writes every word before any in-range read
        plan = '{
            row(1, KIND_READ,     -1,     0,      0,      0,      32'h0,        32'h0, 0),
            row(1, KIND_CLEAR,    -32768, 32767,  0,      -1,     32'hDEADBEEF, 32'h0, 1),
            row(1, KIND_READ,     0,      0,      -32768, 32767,  32'hFFFFFFFF,
                32'hDEADBEEF, 1),
            row(1, KIND_READ,     255,    255,    1,      1,      32'h0, 32'hDEADBEEF, 1),
            row(1, KIND_READ,     256,    0,      1,      1,      32'h0,        32'h0, 0),
            row(1, KIND_READ,     0,      256,    1,      1,      32'h0,        32'h0, 0),
            row(1, KIND_READ,     -32768, -32768, 1,      1,      32'h0,        32'h0, 0),
            row(1, KIND_FILL,     10,     10,     4,      3,      32'h0,        32'h0, 1),
            row(1, KIND_READ,     13,     12,     0,      0,      32'h1,        32'h0, 1),
            row(1, KIND_READ,     14,     12,     0,      0,      32'h1, 32'hDEADBEEF, 1),
            row(1, KIND_FILL,     50,     50,     0,      7,      32'h1,        32'h0, 0),
            row(1, KIND_FILL,     50,     50,     7,      -5,     32'h1,        32'h0, 0),
            row(1, KIND_FILL,     50,     50,     -32768, 32767,  32'h1,        32'h0, 0),
            row(1, KIND_FILL,     -20,    5,      20,     5,      32'h1,        32'h0, 0),
            row(1, KIND_OUTLINE,  256,    5,      5,      5,      32'h1,        32'h0, 0),
            row(1, KIND_OUTLINE,  5,      256,    5,      5,      32'h1,        32'h0, 0),
            row(1, KIND_FILL,     -32768, -32768, 32767,  32767,  32'h1,        32'h0, 0),
            row(0, KIND_FILL,     -3,     250,    6,      10,     32'h0F0F0F0F, 32'h0, 0),
            row(0, KIND_OUTLINE,  20,     20,     5,      4,      32'hA5A5A5A5, 32'h0, 0),
            row(0, KIND_OUTLINE,  40,     40,     1,      1,      32'h5A5A5A5A, 32'h0, 0),
            row(0, KIND_OUTLINE,  -100,   -100,   32767,  32767,  32'h13579BDF, 32'h0, 0),
            row(0, KIND_FILL,     200,    200,    32767,  32767,  32'h2468ACE0, 32'h0, 0),
            row(0, KIND_READ,     22,     20,     7,      7,      32'hFFFFFFFF, 32'h0, 0),
            row(0, KIND_READ,     21,     21,     0,      0,      32'h0,        32'h0, 0),
            row(0, KIND_READ,     0,      255,    0,      0,      32'h0,        32'h0, 0),
            row(0, KIND_READ,     230,    230,    0,      0,      32'h0,        32'h0, 0),
            row(0, KIND_OUTLINE,  5,      -10,    3,      11,     32'hC3C3C3C3, 32'h0, 0)
        };

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i])
            issue(plan[i].cmd, int'($urandom_range(5)), plan[i].typed, plan[i].res);
        drain();

        for (p = 0; p < PHASES; p++) begin
            set_area(phase_w[p], phase_h[p]);
            gap_max = (p % 3 == 2) ? 0 : 5;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll_cmd(cmd);
                issue(cmd, int'($urandom_range(gap_max)), 1'b0, '0);
            end
            drain();
        end

        $display("covered %0d fills, %0d outlines, %0d clears, %0d pixel reads",
                 kind_seen[KIND_FILL], kind_seen[KIND_OUTLINE], kind_seen[KIND_CLEAR],
                 kind_seen[KIND_READ]);
        $display("over %0d area settings, %0d result beats compared, %0d mismatches",
                 settings_used, results_seen, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
